/* sv/clcd_pkg.sv */
// shared types, codes and init tables for the character lcd write sequencer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package clcd_pkg;

    // field widths
    localparam int ACTION_W  = 2;
    localparam int BYTE_W    = 8;
    localparam int NIB_W     = 4;
    localparam int HOLD_W    = 17;
    localparam int SUM_W     = 12;   // gap + settle + longest init wait
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int SUB_W     = 2;
    localparam int IDX_W     = 3;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // action codes on the input
    localparam logic [ACTION_W-1:0] ACT_BYTE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_NIB  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PWR  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_RSVD = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NIBBLE_GAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_SETTLE  = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] ENABLE_PULSE_RST = 8'd2;
    localparam logic [CFG_W-1:0] NIBBLE_GAP_RST   = 8'd5;
    localparam logic [CFG_W-1:0] BYTE_SETTLE_RST  = 8'd50;

    // power-on sequence constants
    localparam logic [HOLD_W-1:0] POWERON_IDLE_US = 17'd100000;
    localparam logic [NIB_W-1:0]  PWR_NIBBLE      = 4'h3;
    localparam logic [SUM_W-1:0]  PWR_NIB_WAIT_US = 12'd40;
    localparam logic [IDX_W-1:0]  INIT_LAST       = 3'd4;
    localparam logic [SUB_W-1:0]  SUB_LAST        = 2'd3;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_NIB  = 2'd1,
        KIND_PWR  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PWR  = 4'b0010,
        ST_NIB  = 4'b0100,
        ST_BYTE = 4'b1000
    } t_state;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data_byte;
        logic              select_data;
    } t_cmd;

    typedef struct packed {
        logic [CFG_W-1:0] enable_pulse_us;
        logic [CFG_W-1:0] nibble_gap_us;
        logic [CFG_W-1:0] byte_settle_us;
    } t_cfg;

    typedef struct packed {
        logic              rs_level;
        logic [NIB_W-1:0]  data_nibble;
        logic              enable_level;
        logic [HOLD_W-1:0] hold_us;
        logic              last;
    } t_step;

    typedef struct packed {
        logic busy;
        logic pwr;
        logic rs;
    } t_bk_status;

    // commands sent by the power-on sequence
    function automatic logic [BYTE_W-1:0] init_cmd(input logic [IDX_W-1:0] idx);
        case (idx)
            3'd0, 3'd1: init_cmd = 8'h2C;
            3'd2:       init_cmd = 8'h0C;
            3'd3:       init_cmd = 8'h01;
            3'd4:       init_cmd = 8'h06;
            default:    init_cmd = 8'h00;
        endcase
    endfunction

    // extra wait after each power-on command
    function automatic logic [SUM_W-1:0] init_wait(input logic [IDX_W-1:0] idx);
        case (idx)
            3'd0:       init_wait = 12'd40;
            3'd1, 3'd2: init_wait = 12'd38;
            3'd3:       init_wait = 12'd2000;
            3'd4:       init_wait = 12'd53;
            default:    init_wait = 12'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

/* sv/clcd_front.sv */
// front stage: accepts input items, drops the unused action code, classifies
// depends on clcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module clcd_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [clcd_pkg::ACTION_W-1:0]    i_action,
    input  wire logic [clcd_pkg::BYTE_W-1:0]      i_data_byte,
    input  wire logic                             i_select_data,
    output logic                                  o_cmd_valid,
    input  wire logic                             i_cmd_ready,
    output clcd_pkg::t_cmd                        o_cmd
);

    logic           r_valid;
    clcd_pkg::t_cmd r_cmd;
    clcd_pkg::t_cmd n_cmd;
    logic           w_take;

    assign o_ready = !r_valid || i_cmd_ready;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_cmd.data_byte   = i_data_byte;
        n_cmd.select_data = i_select_data;
        case (i_action)
            clcd_pkg::ACT_BYTE: n_cmd.kind = clcd_pkg::KIND_BYTE;
            clcd_pkg::ACT_NIB:  n_cmd.kind = clcd_pkg::KIND_NIB;
            clcd_pkg::ACT_PWR:  n_cmd.kind = clcd_pkg::KIND_PWR;
            default:            n_cmd.kind = clcd_pkg::KIND_BYTE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            // reserved action makes no steps, so it never enters the queue
            r_valid <= (i_action != clcd_pkg::ACT_RSVD);
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

`default_nettype wire

/* sv/clcd_fifo.sv */
// small command queue between front and back, flop storage
// depends on clcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module clcd_fifo #(
    parameter int DEPTH = clcd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire clcd_pkg::t_cmd i_cmd,
    output logic                o_valid,
    input  wire logic           i_ready,
    output clcd_pkg::t_cmd      o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    clcd_pkg::t_cmd  r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_ready && o_valid;
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointers wrap at the depth
    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        bump = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* sv/clcd_back.sv */
// back stage: steps through the pin states of each command into an output register
// depends on clcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module clcd_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire clcd_pkg::t_cfg       i_cfg,
    input  wire logic                 i_cmd_valid,
    output logic                      o_cmd_ready,
    input  wire clcd_pkg::t_cmd       i_cmd,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output clcd_pkg::t_step           o_step,
    output clcd_pkg::t_bk_status      o_status
);

    clcd_pkg::t_state                r_state;
    clcd_pkg::t_state                n_state;
    logic                            r_pwr;
    logic                            n_pwr;
    logic                            r_rs;
    logic                            n_rs;
    logic [clcd_pkg::BYTE_W-1:0]     r_byte;
    logic [clcd_pkg::BYTE_W-1:0]     n_byte;
    logic [clcd_pkg::SUB_W-1:0]      r_sub;
    logic [clcd_pkg::SUB_W-1:0]      n_sub;
    logic [clcd_pkg::IDX_W-1:0]      r_idx;
    logic [clcd_pkg::IDX_W-1:0]      n_idx;
    logic                            r_out_valid;
    clcd_pkg::t_step                 r_out;

    clcd_pkg::t_step                 w_step;
    logic                            w_step_valid;
    logic                            w_load;
    logic                            w_take_new;
    logic [clcd_pkg::BYTE_W-1:0]     w_cur_byte;
    logic [clcd_pkg::SUM_W-1:0]      w_extra;
    logic [clcd_pkg::SUM_W-1:0]      w_gap_hold;

    assign w_step_valid = (r_state != clcd_pkg::ST_IDLE);
    assign w_load       = w_step_valid && (!r_out_valid || i_ready);
    assign w_take_new   = (r_state == clcd_pkg::ST_IDLE) || (w_load && w_step.last);
    assign o_cmd_ready  = w_take_new;

    // byte source: fixed init table during power-on, otherwise the item byte
    assign w_cur_byte = r_pwr ? clcd_pkg::init_cmd(r_idx) : r_byte;

    // step fields for the current position
    always_comb begin
        w_step     = '0;
        w_extra    = '0;
        w_gap_hold = '0;
        case (r_state)
            clcd_pkg::ST_PWR: begin
                w_step.hold_us = clcd_pkg::POWERON_IDLE_US;
            end
            clcd_pkg::ST_NIB: begin
                w_extra            = r_pwr ? clcd_pkg::PWR_NIB_WAIT_US : '0;
                w_gap_hold         = {4'b0, i_cfg.nibble_gap_us} + w_extra;
                w_step.rs_level    = r_rs;
                w_step.data_nibble = r_pwr ? clcd_pkg::PWR_NIBBLE : r_byte[3:0];
                w_step.enable_level = !r_sub[0];
                w_step.hold_us     = r_sub[0] ? {5'b0, w_gap_hold}
                                              : {9'b0, i_cfg.enable_pulse_us};
                w_step.last        = r_sub[0] && !r_pwr;
            end
            clcd_pkg::ST_BYTE: begin
                // settle and the init wait land on the low nibble's gap only
                w_extra            = r_sub[1] ? ({4'b0, i_cfg.byte_settle_us}
                                     + (r_pwr ? clcd_pkg::init_wait(r_idx) : '0)) : '0;
                w_gap_hold         = {4'b0, i_cfg.nibble_gap_us} + w_extra;
                w_step.rs_level    = r_rs;
                w_step.data_nibble = r_sub[1] ? w_cur_byte[3:0] : w_cur_byte[7:4];
                w_step.enable_level = !r_sub[0];
                w_step.hold_us     = r_sub[0] ? {5'b0, w_gap_hold}
                                              : {9'b0, i_cfg.enable_pulse_us};
                w_step.last        = (r_sub == clcd_pkg::SUB_LAST)
                                     && (!r_pwr || r_idx == clcd_pkg::INIT_LAST);
            end
            default: begin
                w_step = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_pwr   = r_pwr;
        n_rs    = r_rs;
        n_byte  = r_byte;
        n_sub   = r_sub;
        n_idx   = r_idx;
        if (w_load) begin
            case (r_state)
                clcd_pkg::ST_PWR: begin
                    n_state = clcd_pkg::ST_NIB;
                    n_sub   = '0;
                end
                clcd_pkg::ST_NIB: begin
                    if (r_sub[0]) begin
                        n_state = clcd_pkg::ST_BYTE;
                        n_sub   = '0;
                        n_idx   = '0;
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
                clcd_pkg::ST_BYTE: begin
                    if (r_sub == clcd_pkg::SUB_LAST) begin
                        n_idx = r_idx + 1'b1;
                    end
                    n_sub = r_sub + 1'b1;
                end
                default: begin
                    n_state = r_state;
                end
            endcase
            if (w_step.last) begin
                n_state = clcd_pkg::ST_IDLE;
                n_pwr   = 1'b0;
            end
        end
        if (w_take_new && i_cmd_valid) begin
            n_byte = i_cmd.data_byte;
            n_sub  = '0;
            case (i_cmd.kind)
                clcd_pkg::KIND_BYTE: begin
                    n_state = clcd_pkg::ST_BYTE;
                    n_pwr   = 1'b0;
                    n_rs    = i_cmd.select_data;
                end
                clcd_pkg::KIND_NIB: begin
                    n_state = clcd_pkg::ST_NIB;
                    n_pwr   = 1'b0;
                end
                clcd_pkg::KIND_PWR: begin
                    n_state = clcd_pkg::ST_PWR;
                    n_pwr   = 1'b1;
                    n_rs    = 1'b0;
                end
                default: begin
                    n_state = clcd_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clcd_pkg::ST_IDLE;
            r_pwr       <= 1'b0;
            r_rs        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pwr   <= n_pwr;
            r_rs    <= n_rs;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_sub  <= n_sub;
        r_idx  <= n_idx;
        if (w_load) begin
            r_out <= w_step;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_step        = r_out;
    assign o_status.busy = w_step_valid;
    assign o_status.pwr  = r_pwr;
    assign o_status.rs   = r_rs;

endmodule

`default_nettype wire

/* sv/char_lcd_4bit_write_sequencer_unit.sv */
// top level of the 4-bit character lcd write sequencer: config registers,
// front stage, command queue and pin-step sequencer; depends on clcd_pkg,
// clcd_front, clcd_fifo and clcd_back
//
// usage
//   input stream (s_axis): one item per request; tdata carries action,
//   data_byte and select_data. action 0 sends a byte (4 pin steps), 1 sends
//   the low nibble of data_byte with the present rs level (2 steps), 2 runs
//   the power-on sequence (23 steps), 3 is swallowed with no steps.
//   output stream (m_axis): one item per pin step, rs / db7..db4 / e plus the
//   hold time in microseconds; tlast marks the final step of an input item.
//   config port: i_cfg_we writes i_cfg_wdata into register i_cfg_index
//   (0 enable pulse, 1 nibble gap, 2 byte settle); other indexes are ignored.
//   write only while the block is idle.
// timing
//   the back sequencer emits one pin step per cycle while the receiver keeps
//   tready high. an item passes the front register, queue, sequencer state
//   and output register before its first step appears. the front and queue
//   keep taking items while the sequencer works, so the input only stalls
//   once the queue is full.
// reset
//   synchronous, active low: registers return to 2 / 5 / 50 us, rs level to
//   command, queue empties. no clearing pass is needed.
// stalls
//   when the receiver holds tready low the output register keeps its step,
//   the sequencer waits, and backpressure reaches the input via the queue.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_4bit_write_sequencer_unit #(
    parameter int QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input items
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // [1:0] action, [9:2] data_byte, [10] select_data, [15:11] zero
    input  wire logic [15:0]                       i_s_axis_tdata,
    // pin steps
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // [0] rs_level, [4:1] data_nibble, [5] enable_level, [22:6] hold_us, [23] zero
    output logic [23:0]                            o_m_axis_tdata,
    output logic                                   o_m_axis_tlast,
    // config write port
    input  wire logic                              i_cfg_we,
    input  wire logic [clcd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [clcd_pkg::CFG_W-1:0]        i_cfg_wdata
);

    // timing registers
    logic [clcd_pkg::CFG_W-1:0] r_enable_pulse;
    logic [clcd_pkg::CFG_W-1:0] r_nibble_gap;
    logic [clcd_pkg::CFG_W-1:0] r_byte_settle;
    clcd_pkg::t_cfg             w_cfg;

    // front -> queue -> back
    logic                       w_fr_valid;
    logic                       w_fr_ready;
    clcd_pkg::t_cmd             w_fr_cmd;
    logic                       w_q_valid;
    logic                       w_q_ready;
    clcd_pkg::t_cmd             w_q_cmd;
    clcd_pkg::t_step            w_step;
    clcd_pkg::t_bk_status       w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_pulse <= clcd_pkg::ENABLE_PULSE_RST;
            r_nibble_gap   <= clcd_pkg::NIBBLE_GAP_RST;
            r_byte_settle  <= clcd_pkg::BYTE_SETTLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                clcd_pkg::REG_ENABLE_PULSE: r_enable_pulse <= i_cfg_wdata;
                clcd_pkg::REG_NIBBLE_GAP:   r_nibble_gap   <= i_cfg_wdata;
                clcd_pkg::REG_BYTE_SETTLE:  r_byte_settle  <= i_cfg_wdata;
                default: begin
                    // index past the register list: ignored
                end
            endcase
        end
    end

    assign w_cfg.enable_pulse_us = r_enable_pulse;
    assign w_cfg.nibble_gap_us   = r_nibble_gap;
    assign w_cfg.byte_settle_us  = r_byte_settle;

    // front: takes items, drops the reserved action
    clcd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_action      (i_s_axis_tdata[1:0]),
        .i_data_byte   (i_s_axis_tdata[9:2]),
        .i_select_data (i_s_axis_tdata[10]),
        .o_cmd_valid   (w_fr_valid),
        .i_cmd_ready   (w_fr_ready),
        .o_cmd         (w_fr_cmd)
    );

    // queue decouples item intake from pin stepping
    clcd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_cmd   (w_fr_cmd),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_cmd   (w_q_cmd)
    );

    // back: one pin step per cycle into the output register while the receiver takes them
    clcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (w_q_cmd),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_step      (w_step),
        .o_status    (w_status)
    );

    assign o_m_axis_tdata = {1'b0, w_step.hold_us, w_step.enable_level,
                             w_step.data_nibble, w_step.rs_level};
    assign o_m_axis_tlast = w_step.last;

    // power-on sequence always drives rs low
    a_pwr_rs_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_status.busy && w_status.pwr) |-> !w_status.rs)
        else $error("rs high during power-on sequence");

    // enable-high steps hold for the programmed pulse width
    a_pulse_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_step.enable_level)
            |-> (w_step.hold_us == {9'b0, r_enable_pulse}))
        else $error("enable pulse hold differs from register");

    // an item never ends on an enable-high step
    a_last_on_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> !w_step.enable_level)
        else $error("last step has enable high");

endmodule

`default_nettype wire

/* verif/clcd_pin_step_checker.sv */
// pin-step checker for the 4-bit character lcd write sequencer: watches the
// input, output and register-write channels, predicts every pin step and compares
// depends on clcd_pkg for field widths, action codes and register indexes
`timescale 1ns / 1ps

module clcd_pin_step_checker
    import clcd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_s_tready,
    // [1:0] action, [9:2] data_byte, [10] select_data, [15:11] zero
    input  wire logic [15:0]          i_s_tdata,
    input  wire logic                 i_m_tvalid,
    input  wire logic                 i_m_tready,
    // [0] rs_level, [4:1] data_nibble, [5] enable_level, [22:6] hold_us, [23] zero
    input  wire logic [23:0]          i_m_tdata,
    input  wire logic                 i_m_tlast,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);

    // power-on commands and their extra waits, first entry in the lowest bits
    localparam logic [39:0] PWR_CMD_SEQ  = {8'h06, 8'h01, 8'h0C, 8'h2C, 8'h2C};
    localparam logic [59:0] PWR_WAIT_SEQ = {12'd53, 12'd2000, 12'd38, 12'd38, 12'd40};
    localparam int          PWR_CMD_CNT  = 5;
    localparam int          MAX_REPORTS  = 10;

    t_step            steps_due [$];
    logic [CFG_W-1:0] pulse_us;
    logic [CFG_W-1:0] gap_us;
    logic [CFG_W-1:0] settle_us;
    logic             rs_now;
    int               fails;
    int               checked;

    function automatic t_step pin_step(input logic rs, input logic [NIB_W-1:0] nib,
                                       input logic en, input logic [HOLD_W-1:0] hold);
        t_step s;
        s.rs_level     = rs;
        s.data_nibble  = nib;
        s.enable_level = en;
        s.hold_us      = hold;
        s.last         = 1'b0;
        return s;
    endfunction

    // one strobe: e high for the pulse, then e low for the gap plus extra
    task automatic add_strobe(input logic [NIB_W-1:0] nib, input logic [HOLD_W-1:0] extra);
        steps_due.push_back(pin_step(rs_now, nib, 1'b1, HOLD_W'(pulse_us)));
        steps_due.push_back(pin_step(rs_now, nib, 1'b0, HOLD_W'(gap_us) + extra));
    endtask

    task automatic add_byte(input logic [BYTE_W-1:0] b, input logic rs,
                            input logic [HOLD_W-1:0] extra);
        rs_now = rs;
        add_strobe(b[7:4], '0);
        add_strobe(b[3:0], HOLD_W'(settle_us) + extra);
    endtask

    task automatic predict_item(input logic [15:0] word);
        logic [ACTION_W-1:0] act;
        logic [BYTE_W-1:0]   b;
        logic                sel;
        t_step               tail;
        act = word[1:0];
        b   = word[9:2];
        sel = word[10];
        case (act)
            ACT_BYTE: add_byte(b, sel, '0);
            ACT_NIB:  add_strobe(b[3:0], '0);
            ACT_PWR: begin
                rs_now = 1'b0;
                steps_due.push_back(pin_step(1'b0, '0, 1'b0, POWERON_IDLE_US));
                add_strobe(PWR_NIBBLE, HOLD_W'(PWR_NIB_WAIT_US));
                for (int i = 0; i < PWR_CMD_CNT; i++) begin
                    add_byte(PWR_CMD_SEQ[8*i +: 8], 1'b0, HOLD_W'(PWR_WAIT_SEQ[12*i +: 12]));
                end
            end
            default: return;   // unused action: swallowed, no steps
        endcase
        tail = steps_due.pop_back();
        tail.last = 1'b1;
        steps_due.push_back(tail);
    endtask

    task automatic check_step(input logic [23:0] word, input logic tlast);
        t_step got;
        t_step want;
        got = pin_step(word[0], word[4:1], word[5], word[22:6]);
        got.last = tlast;
        checked++;
        if (steps_due.size() == 0) begin
            fails++;
            if (fails <= MAX_REPORTS)
                $display("%0t: unexpected pin step rs=%0d nib=%h e=%0d hold=%0d last=%0d",
                         $realtime, got.rs_level, got.data_nibble, got.enable_level,
                         got.hold_us, got.last);
            return;
        end
        want = steps_due.pop_front();
        if (got.rs_level !== want.rs_level || got.data_nibble !== want.data_nibble ||
            got.enable_level !== want.enable_level || got.hold_us !== want.hold_us ||
            got.last !== want.last) begin
            fails++;
            if (fails <= MAX_REPORTS)
                $display("%0t: pin step %0d exp rs=%0d nib=%h e=%0d hold=%0d last=%0d, got rs=%0d nib=%h e=%0d hold=%0d last=%0d",
                         $realtime, checked, want.rs_level, want.data_nibble,
                         want.enable_level, want.hold_us, want.last, got.rs_level,
                         got.data_nibble, got.enable_level, got.hold_us, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            steps_due.delete();
            pulse_us  = ENABLE_PULSE_RST;
            gap_us    = NIBBLE_GAP_RST;
            settle_us = BYTE_SETTLE_RST;
            rs_now    = 1'b0;
            fails     = 0;
            checked   = 0;
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_step(i_m_tdata, i_m_tlast);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ENABLE_PULSE: pulse_us  = i_cfg_wdata;
                    REG_NIBBLE_GAP:   gap_us    = i_cfg_wdata;
                    REG_BYTE_SETTLE:  settle_us = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                predict_item(i_s_tdata);
        end
        o_pending    <= steps_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

/* verif/char_lcd_4bit_write_sequencer_unit_tb.sv */
// testbench top for the 4-bit character lcd write sequencer: clock, reset,
// input items, register writes, random output stalls and the verdict
// depends on clcd_pkg, the block and clcd_pin_step_checker
`timescale 1ns / 1ps

module char_lcd_4bit_write_sequencer_unit_tb;
    import clcd_pkg::*;

    localparam int CLK_HALF        = 4;      // 8 ns period
    localparam int RESET_CYCLES    = 2;
    localparam int ITEMS_PER_PHASE = 62;     // counted items per register setting
    localparam int NUM_SETTINGS    = 6;
    localparam int LONG_HOLD       = 400;    // receiver hold-off in cycles
    localparam int SETTLE_CYCLES   = 16;     // covers the front, queue and output registers and swallowed items
    localparam int WATCHDOG_LIMIT  = 4000;   // cycles with no item moving
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [23:0]          m_tdata;
    logic                 m_tlast;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_wdata   = '0;

    int fail_count;
    int pending;
    int checked;

    // shared between the sender and receiver processes
    bit no_idle        = 1'b0;   // stretch with no idling on either side
    int sink_long_hold = 0;      // request for one long receiver hold-off
    int long_holds     = 0;
    int idle_cycles    = 0;

    // item counts per kind for the closing summary
    int n_byte = 0;
    int n_nib  = 0;
    int n_pwr  = 0;
    int n_skip = 0;

    char_lcd_4bit_write_sequencer_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    clcd_pin_step_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    // watchdog: any accepted item on either stream restarts the count
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no item moved for %0d cycles, %0d steps pending",
                         idle_cycles, pending);
                $display("char_lcd_4bit_write_sequencer_unit_tb: FAIL");
                $finish;
            end
        end
    end

    // receiver: random stall before each pin step, or one long hold-off when asked
    initial begin : pin_step_sink
        int wait_cycles;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (sink_long_hold > 0) begin
                wait_cycles    = sink_long_hold;
                sink_long_hold = 0;
                long_holds++;
            end else begin
                wait_cycles = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // offer one item after a random gap and wait until it is taken;
    // tvalid stays high when the next item follows with no gap
    task automatic push_item(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b,
                             input logic sel);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, sel, b, act};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        case (act)
            ACT_BYTE: n_byte++;
            ACT_NIB:  n_nib++;
            ACT_PWR:  n_pwr++;
            default:  n_skip++;
        endcase
    endtask

    // mostly byte and nibble sends, some power-on runs, a few unused codes
    task automatic push_random_item(output bit counted);
        int                  pick;
        logic [ACTION_W-1:0] act;
        pick = $urandom_range(0, 99);
        if (pick < 48)      act = ACT_BYTE;
        else if (pick < 80) act = ACT_NIB;
        else if (pick < 92) act = ACT_PWR;
        else                act = ACT_RSVD;
        push_item(act, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        counted = (act != ACT_RSVD);
    endtask

    // stop offering and wait until every predicted pin step has come out;
    // the checker's count is registered, hence the first cycle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // back-to-back register writes, the unused index last with random data
    task automatic program_regs(input logic [CFG_W-1:0] pulse, input logic [CFG_W-1:0] gap,
                                input logic [CFG_W-1:0] settle);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ENABLE_PULSE;
        cfg_wdata <= pulse;
        @(posedge clk);
        cfg_index <= REG_NIBBLE_GAP;
        cfg_wdata <= gap;
        @(posedge clk);
        cfg_index <= REG_BYTE_SETTLE;
        cfg_wdata <= settle;
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_wdata <= CFG_W'($urandom_range(0, 255));
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        int               counted;
        bit               took;
        logic [CFG_W-1:0] pulse;
        logic [CFG_W-1:0] gap;
        logic [CFG_W-1:0] settle;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with the reset register values
        push_item(ACT_NIB,  8'h0A, 1'b0);   // nibble before any byte: rs from reset
        push_item(ACT_BYTE, 8'h00, 1'b0);
        push_item(ACT_BYTE, 8'hFF, 1'b1);
        push_item(ACT_NIB,  8'hFF, 1'b0);   // rs stays at data, select ignored
        push_item(ACT_NIB,  8'hF0, 1'b1);   // only the low nibble goes out
        push_item(ACT_BYTE, 8'hA5, 1'b0);
        push_item(ACT_BYTE, 8'h5A, 1'b1);
        push_item(ACT_PWR,  8'h00, 1'b1);   // power-on forces rs back to command
        push_item(ACT_NIB,  8'h05, 1'b0);
        push_item(ACT_RSVD, 8'hFF, 1'b1);   // unused code: no steps, rs untouched
        push_item(ACT_NIB,  8'h0C, 1'b1);
        push_item(ACT_BYTE, 8'h3C, 1'b1);
        push_item(ACT_RSVD, 8'h00, 1'b0);
        push_item(ACT_NIB,  8'h03, 1'b0);   // rs still data after the swallowed item
        push_item(ACT_PWR,  8'hFF, 1'b0);
        push_item(ACT_PWR,  8'h81, 1'b1);   // back-to-back power-on runs

        for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
            if (phase > 0) begin
                case (phase)
                    1: begin pulse = 8'd1;   gap = 8'd0;   settle = 8'd0;   end  // minimum
                    2: begin pulse = 8'd255; gap = 8'd255; settle = 8'd255; end  // maximum
                    3: begin pulse = 8'd0;   gap = 8'd1;   settle = 8'd255; end  // zero pulse
                    default: begin
                        pulse  = CFG_W'($urandom_range(1, 255));
                        gap    = CFG_W'($urandom_range(0, 255));
                        settle = CFG_W'($urandom_range(0, 255));
                    end
                endcase
                program_regs(pulse, gap, settle);
            end
            // let the block fill up and stall its input behind a held-off receiver
            if (phase == 2)
                sink_long_hold = LONG_HOLD;
            counted = (phase == 0) ? 14 : 0;
            while (counted < ITEMS_PER_PHASE) begin
                if (counted % 16 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                push_random_item(took);
                if (took)
                    counted++;
            end
            no_idle = 1'b0;
            drain();
        end

        $display("run covered %0d byte, %0d nibble, %0d power-on and %0d unused-code items",
                 n_byte, n_nib, n_pwr, n_skip);
        $display("over %0d register settings with %0d long receiver hold-off; %0d pin steps checked",
                 NUM_SETTINGS, long_holds, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("char_lcd_4bit_write_sequencer_unit_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d pin steps still expected", fail_count, pending);
            $display("char_lcd_4bit_write_sequencer_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
